### rtl/display_scan_keypad_controller_unit_defines.svh
// assertion macros used by the rtl core (dskc_core)
`ifndef DISPLAY_SCAN_KEYPAD_CONTROLLER_UNIT_DEFINES_SVH
`define DISPLAY_SCAN_KEYPAD_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DSKC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dskc assertion failed");
`define DSKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dskc assertion failed");
`else
`define DSKC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DSKC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/dskc_pkg.sv
package dskc_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SCAN = 2'd1;
  localparam logic [1:0] OP_KEY  = 2'd2;

  localparam logic [10:0] LEVEL_IDLE = 11'd1024;
  localparam logic [3:0]  BLANK_CODE = 4'd15;
  localparam int          KEYS       = 8;

  // ladder ranges per button, low bound inclusive, high bound exclusive
  localparam logic [10:0] KEY_LOW  [KEYS] = '{11'd421, 11'd470, 11'd520, 11'd560,
                                              11'd590, 11'd640, 11'd650, 11'd700};
  localparam logic [10:0] KEY_HIGH [KEYS] = '{11'd470, 11'd520, 11'd560, 11'd590,
                                              11'd640, 11'd650, 11'd700, 11'd750};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  cell_index;
    logic [7:0]  cell_value;
    logic [10:0] adc_level;
  } req_t;

  typedef struct packed {
    logic       drive_valid;
    logic [3:0] board_address;
    logic [3:0] segment_code;
    logic       indicator_on;
    logic       button_event;
    logic [3:0] button_id;
  } rsp_t;

endpackage

### rtl/dskc_if.sv
interface dskc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  cell_index;
  logic [7:0]  cell_value;
  logic [10:0] adc_level;

  modport source (output valid, opcode, cell_index, cell_value, adc_level, input ready);
  modport sink   (input valid, opcode, cell_index, cell_value, adc_level, output ready);
endinterface

interface dskc_rsp_if;
  logic       valid;
  logic       ready;
  logic       drive_valid;
  logic [3:0] board_address;
  logic [3:0] segment_code;
  logic       indicator_on;
  logic       button_event;
  logic [3:0] button_id;

  modport source (output valid, drive_valid, board_address, segment_code, indicator_on,
                  button_event, button_id, input ready);
  modport sink   (input valid, drive_valid, board_address, segment_code, indicator_on,
                  button_event, button_id, output ready);
endinterface

### rtl/dskc_key_decode.sv
module dskc_key_decode (
  input  logic [10:0] level,
  output logic [3:0]  button_id
);
  import dskc_pkg::*;

  // ranges are disjoint, first hit wins
  always_comb begin
    button_id = '0;
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (level >= KEY_LOW[k] && level < KEY_HIGH[k]) begin
        button_id = 4'(k + 1);
      end
    end
  end
endmodule

### rtl/dskc_core.sv
`include "display_scan_keypad_controller_unit_defines.svh"

module dskc_core #(
  parameter int CELLS = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  dskc_pkg::req_t item,
  output dskc_pkg::rsp_t result
);
  import dskc_pkg::*;

  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CELLS - 1);

  logic [7:0]       cells [CELLS];
  logic [IDX_W-1:0] scan_index;
  logic             press_latch;

  logic [3:0] key_id;
  logic [7:0] scan_cell;
  logic       load_hit;
  logic       key_new;
  logic       clear_hit;

  dskc_key_decode u_key_decode (
    .level     (item.adc_level),
    .button_id (key_id)
  );

  assign scan_cell = cells[scan_index];
  assign load_hit  = {1'b0, item.cell_index} < 5'(CELLS);
  assign key_new   = !press_latch && item.adc_level < LEVEL_IDLE;
  assign clear_hit = key_id != '0 && {1'b0, key_id} < 5'(CELLS);

  always_comb begin
    result = '0;
    unique case (item.opcode)
      OP_SCAN: begin
        result.drive_valid = 1'b1;
        if (scan_cell != '0) begin
          result.board_address = 4'(scan_index);
          result.segment_code  = scan_cell[3:0];
          result.indicator_on  = 1'b1;
        end else begin
          result.board_address = BLANK_CODE;
          result.segment_code  = BLANK_CODE;
        end
      end
      OP_KEY: begin
        if (key_new && key_id != '0) begin
          result.button_event = 1'b1;
          result.button_id    = key_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cells[i] <= '0;
      end
      scan_index  <= '0;
      press_latch <= 1'b0;
    end else if (fire) begin
      unique case (item.opcode)
        OP_LOAD: begin
          if (load_hit) begin
            cells[item.cell_index[IDX_W-1:0]] <= item.cell_value;
          end
        end
        OP_SCAN: begin
          scan_index <= (scan_index == LAST) ? '0 : scan_index + 1'b1;
        end
        OP_KEY: begin
          if (press_latch) begin
            if (item.adc_level == LEVEL_IDLE) begin
              press_latch <= 1'b0;
            end
          end else if (key_new) begin
            press_latch <= 1'b1;
            // pressed button blanks its own cell
            if (clear_hit) begin
              cells[key_id[IDX_W-1:0]] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `DSKC_ASSERT_IMPLIES(a_scan_in_range, clk, rst, 1'b1, scan_index <= LAST)
  `DSKC_ASSERT_NEXT(a_scan_wrap, clk, rst,
                    fire && item.opcode == OP_SCAN && scan_index == LAST, scan_index == '0)
  `DSKC_ASSERT_NEXT(a_press_sets_latch, clk, rst,
                    fire && item.opcode == OP_KEY && key_new, press_latch)
  `DSKC_ASSERT_IMPLIES(a_event_not_drive, clk, rst,
                       result.button_event, !result.drive_valid && result.button_id != '0)
endmodule

### rtl/display_scan_keypad_controller_unit.sv
// Display scan and keypad controller.
// req channel carries one item per handshake: opcode 0 loads a byte into a
// display cell, opcode 1 is a scan tick, opcode 2 is a keypad ladder sample.
// rsp channel returns exactly one item per accepted request, in order: the
// pin drive fields for a scan tick, a button event for a new key press, and
// all zero otherwise.
// A request accepted into the input register is processed, and its response
// loaded into the output register, once that register is free or being taken.
// Throughput: one item per cycle while the receiver keeps taking responses, set
// by the single processing stage that reads and updates the cell store, scan
// position and press latch in the same cycle. An input register and an output
// register part the two channels; when the receiver stalls, the response is held,
// and req.ready stays high only while the input register is empty.
// Reset (synchronous, active high) blanks every cell, returns the scan position
// to cell zero, releases the press latch and empties both registers.
module display_scan_keypad_controller_unit #(
  parameter int CELLS = 9
) (
  input logic        clk,
  input logic        rst,
  dskc_req_if.sink   req,
  dskc_rsp_if.source rsp
);
  import dskc_pkg::*;

  logic stage_valid;
  req_t stage_item;
  logic out_valid;
  rsp_t out_data;
  rsp_t result;
  logic advance;
  logic fire;

  assign advance   = !out_valid || rsp.ready;
  assign fire      = stage_valid && advance;
  assign req.ready = !stage_valid || advance;

  dskc_core #(
    .CELLS (CELLS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (req.ready) begin
        stage_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item <= '{opcode:     req.opcode,
                      cell_index: req.cell_index,
                      cell_value: req.cell_value,
                      adc_level:  req.adc_level};
    end
    if (fire) begin
      out_data <= result;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.drive_valid   = out_data.drive_valid;
  assign rsp.board_address = out_data.board_address;
  assign rsp.segment_code  = out_data.segment_code;
  assign rsp.indicator_on  = out_data.indicator_on;
  assign rsp.button_event  = out_data.button_event;
  assign rsp.button_id     = out_data.button_id;
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dskc_pkg::*;

  localparam int          CELLS          = 9;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          PHASE_ITEMS    = 370;

  logic clk = 1'b0;
  logic rst;

  dskc_req_if req_bus ();
  dskc_rsp_if rsp_bus ();

  display_scan_keypad_controller_unit #(.CELLS(CELLS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #2 clk = ~clk;

  // shadow copy of the controller state
  logic [7:0] cell_shadow [CELLS];
  logic [3:0] scan_pos;
  logic       key_latched;

  rsp_t pending_responses [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int checked       = 0;
  int n_load        = 0;
  int n_scan        = 0;
  int n_key         = 0;
  int n_unused      = 0;
  int n_events      = 0;
  bit key_down      = 1'b0;

  function automatic void ladder_bounds(input int k, output int lo, output int hi);
    case (k)
      0: begin lo = 421; hi = 470; end
      1: begin lo = 470; hi = 520; end
      2: begin lo = 520; hi = 560; end
      3: begin lo = 560; hi = 590; end
      4: begin lo = 590; hi = 640; end
      5: begin lo = 640; hi = 650; end
      6: begin lo = 650; hi = 700; end
      default: begin lo = 700; hi = 750; end
    endcase
  endfunction

  function automatic rsp_t controller_response(input req_t item);
    rsp_t       r;
    logic [7:0] c;
    logic [3:0] btn;
    int         lo;
    int         hi;
    r   = '0;
    btn = 4'd0;
    case (item.opcode)
      OP_LOAD: begin
        if (item.cell_index < CELLS) cell_shadow[item.cell_index] = item.cell_value;
      end
      OP_SCAN: begin
        c = cell_shadow[scan_pos];
        r.drive_valid = 1'b1;
        if (c != 8'd0) begin
          r.board_address = scan_pos;
          r.segment_code  = c[3:0];
          r.indicator_on  = 1'b1;
        end else begin
          r.board_address = BLANK_CODE;
          r.segment_code  = BLANK_CODE;
        end
        scan_pos = (scan_pos == CELLS - 1) ? 4'd0 : scan_pos + 4'd1;
      end
      OP_KEY: begin
        if (key_latched) begin
          if (item.adc_level == LEVEL_IDLE) key_latched = 1'b0;
        end else if (item.adc_level < LEVEL_IDLE) begin
          key_latched = 1'b1;
          for (int k = 0; k < 8; k++) begin
            ladder_bounds(k, lo, hi);
            if (item.adc_level >= lo && item.adc_level < hi) btn = 4'(k + 1);
          end
          if (btn != 4'd0) begin
            if (btn < CELLS) cell_shadow[btn] = 8'd0;
            r.button_event = 1'b1;
            r.button_id    = btn;
            n_events++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input logic [3:0] idx,
                                    input logic [7:0] val, input logic [10:0] lvl);
    req_t item;
    item.opcode     = op;
    item.cell_index = idx;
    item.cell_value = val;
    item.adc_level  = lvl;
    return item;
  endfunction

  // mostly press then release, with some noise levels in between
  function automatic logic [10:0] ladder_level();
    int lo;
    int hi;
    int lvl;
    int pick;
    if (key_down) begin
      lvl = ($urandom_range(99) < 75) ? LEVEL_IDLE : $urandom_range(2047);
    end else if ($urandom_range(99) < 80) begin
      ladder_bounds($urandom_range(7), lo, hi);
      pick = $urandom_range(3);
      if (pick == 0) lvl = lo;
      else if (pick == 1) lvl = hi - 1;
      else lvl = $urandom_range(hi - 1, lo);
    end else begin
      lvl = $urandom_range(2047);
    end
    if (lvl < LEVEL_IDLE) key_down = 1'b1;
    else if (lvl == LEVEL_IDLE) key_down = 1'b0;
    return lvl[10:0];
  endfunction

  function automatic req_t random_item();
    req_t item;
    int   pick;
    item.opcode     = 2'($urandom);
    item.cell_index = 4'($urandom);
    item.cell_value = 8'($urandom);
    item.adc_level  = 11'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      item.opcode = OP_LOAD;
      if ($urandom_range(9) != 0) item.cell_index = 4'($urandom_range(CELLS - 1));
      if ($urandom_range(4) == 0) item.cell_value = 8'd0;
    end else if (pick < 65) begin
      item.opcode = OP_SCAN;
    end else if (pick < 96) begin
      item.opcode    = OP_KEY;
      item.adc_level = ladder_level();
    end else begin
      item.opcode = OP_UNUSED;
    end
    return item;
  endfunction

  // entered and left just after a falling edge; valid stays high on return
  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= item.opcode;
    req_bus.cell_index <= item.cell_index;
    req_bus.cell_value <= item.cell_value;
    req_bus.adc_level  <= item.adc_level;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_responses.push_back(controller_response(item));
    case (item.opcode)
      OP_LOAD: n_load++;
      OP_SCAN: n_scan++;
      OP_KEY:  n_key++;
      default: n_unused++;
    endcase
    @(negedge clk);
  endtask

  task automatic release_bus();
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_empty();
    while (pending_responses.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(make_req(OP_SCAN, 4'hF, 8'hFF, 11'h7FF));
    send_item(make_req(OP_LOAD, 4'd0, 8'hFF, 11'h7FF));
    // nonzero cell whose low nibble is zero
    send_item(make_req(OP_LOAD, 4'd8, 8'h10, 11'd0));
    send_item(make_req(OP_LOAD, 4'd9, 8'hAA, 11'd0));
    send_item(make_req(OP_LOAD, 4'hF, 8'h55, 11'd0));
    send_item(make_req(OP_UNUSED, 4'hF, 8'hFF, 11'h7FF));
    send_item(make_req(OP_LOAD, 4'd4, 8'h00, 11'h7FF));
    repeat (CELLS) send_item(make_req(OP_SCAN, 4'd0, 8'd0, 11'd0));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd2047));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd420));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd465));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, LEVEL_IDLE));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd749));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, LEVEL_IDLE));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd421));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, LEVEL_IDLE));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd0));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, LEVEL_IDLE));
    send_item(make_req(OP_KEY, 4'd0, 8'd0, 11'd1025));
    release_bus();
    wait_empty();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall, input int count);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) send_item(random_item());
    release_bus();
    wait_empty();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, PHASE_ITEMS);
    run_random_phase(86, 0, PHASE_ITEMS);
    run_random_phase(0, 86, PHASE_ITEMS);
    run_random_phase(29, 29, PHASE_ITEMS);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    // receiver holds off while items keep coming, so the input side stalls
    repeat (60) send_item(random_item());
    stall_pct = 86;
    repeat (30) send_item(random_item());
    release_bus();
    wait_empty();
    repeat (30) send_item(random_item());
    release_bus();
    wait_empty();
  endtask

  initial begin
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_LOAD;
    req_bus.cell_index = 4'd0;
    req_bus.cell_value = 8'd0;
    req_bus.adc_level  = 11'd0;
    rsp_bus.ready      = 1'b0;
    for (int i = 0; i < CELLS; i++) cell_shadow[i] = 8'd0;
    scan_pos    = 4'd0;
    key_latched = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic();
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $display("%0d responses never arrived", pending_responses.size());
      mismatches++;
    end
    $display("covered %0d loads, %0d scan ticks, %0d keypad samples, %0d unused opcodes",
             n_load, n_scan, n_key, n_unused);
    $display("%0d button events, %0d responses checked, %0d mismatches",
             n_events, checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.drive_valid   = rsp_bus.drive_valid;
      got.board_address = rsp_bus.board_address;
      got.segment_code  = rsp_bus.segment_code;
      got.indicator_on  = rsp_bus.indicator_on;
      got.button_event  = rsp_bus.button_event;
      got.button_id     = rsp_bus.button_id;
      checked++;
      if (pending_responses.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response: drv %b addr %0d seg %0d ind %b evt %b id %0d",
                   got.drive_valid, got.board_address, got.segment_code,
                   got.indicator_on, got.button_event, got.button_id);
        mismatches++;
      end else begin
        want = pending_responses.pop_front();
        if (got.drive_valid !== want.drive_valid || got.board_address !== want.board_address ||
            got.segment_code !== want.segment_code || got.indicator_on !== want.indicator_on ||
            got.button_event !== want.button_event || got.button_id !== want.button_id) begin
          if (mismatches < 10) begin
            $display("mismatch: expected drv %b addr %0d seg %0d ind %b evt %b id %0d",
                     want.drive_valid, want.board_address, want.segment_code,
                     want.indicator_on, want.button_event, want.button_id);
            $display("          actual   drv %b addr %0d seg %0d ind %b evt %b id %0d",
                     got.drive_valid, got.board_address, got.segment_code,
                     got.indicator_on, got.button_event, got.button_id);
          end
          mismatches++;
        end
      end
    end
  end

  // counts cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
